// ===== rtl/core/fcbb_pkg.sv =====
// Package for the frustum cull bounding box block.
// Holds register indexes, reset values and the shared vertex struct. No dependencies.
package fcbb_pkg;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int SCREEN_LIMIT = 1000;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEAR_PLANE  = 2'd0,
    REG_FAR_PLANE   = 2'd1,
    REG_HALF_WIDTH  = 2'd2,
    REG_HALF_HEIGHT = 2'd3
  } reg_idx_t;

  localparam logic signed [31:0] NEAR_RESET = 32'sd0;
  localparam logic signed [31:0] FAR_RESET = 32'sd65536;
  localparam logic [11:0] HALF_RESET = 12'd500;

  // Vertex handed from the front part to the back part.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               div;
    logic               last;
    logic               empty;
  } vert_t;
endpackage

// ===== rtl/core/fcbb_front.sv =====
// Front part: accepts vertices, classifies them and feeds a two-entry queue.
// Depends on fcbb_pkg.
module fcbb_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fcbb_pkg::vert_t      in_vert,
  output logic                 q_valid,
  input  logic                 q_take,
  output fcbb_pkg::vert_t      q_vert
);
  fcbb_pkg::vert_t mem [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push, pop;
  fcbb_pkg::vert_t cls;

  always_comb begin
    cls = in_vert;
    cls.div = in_vert.w > 32'sd0;
  end

  assign in_stall = count == 2'd2;
  assign push = in_valid && !in_stall;
  assign q_valid = count != 2'd0;
  assign pop = q_valid && q_take;
  assign q_vert = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/core/fcbb_div.sv =====
// Iterative signed divider, one quotient bit per cycle, saturating to 32 bits.
// Computes (num * 2^FRACTION_BITS) / den, truncated toward zero, den > 0.
module fcbb_div #(
  parameter int FRACTION_BITS = fcbb_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  localparam int NW = 32 + FRACTION_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dvd, q;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic neg, busy;
  logic [CW-1:0] cnt;
  logic [32:0] trial;
  logic [NW:0] sq;
  logic [31:0] absn;

  assign trial = {rem[31:0], dvd[NW-1]} - {1'b0, dvs};
  assign absn = num[31] ? 32'(-num) : num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {absn, {FRACTION_BITS{1'b0}}};
      dvs <= den;
      neg <= num[31];
      rem <= '0;
      q <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      if (!trial[32]) begin
        rem <= trial;
        q <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[31:0], dvd[NW-1]};
        q <= {q[NW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    sq = neg ? -{1'b0, q} : {1'b0, q};
    if (!neg && q > NW'(32'h7fff_ffff)) quo = 32'sh7fff_ffff;
    else if (neg && q > NW'(33'h8000_0000)) quo = 32'sh8000_0000;
    else quo = sq[31:0];
  end
endmodule

// ===== rtl/core/fcbb_back.sv =====
// Back part: divides, updates the box and runs the plane and screen tests.
// Depends on fcbb_pkg and fcbb_div.
module fcbb_back #(
  parameter int FRACTION_BITS = fcbb_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_take,
  input  fcbb_pkg::vert_t    q_vert,
  input  logic signed [31:0] near_plane,
  input  logic signed [31:0] far_plane,
  input  logic [11:0]        half_width,
  input  logic [11:0]        half_height,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               visible,
  output logic               idle
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_UPD  = 5'b00100,
    S_MAP  = 5'b01000,
    S_TEST = 5'b10000
  } state_t;

  localparam int MW = 48;
  localparam logic signed [MW-1:0] ONE = MW'(1) <<< FRACTION_BITS;
  localparam logic signed [MW-1:0] LIMIT = MW'(fcbb_pkg::SCREEN_LIMIT) <<< FRACTION_BITS;

  state_t state;
  fcbb_pkg::vert_t cur;
  logic box_started;
  logic signed [31:0] min_x, max_x, min_y, max_y, min_z, max_z, px, py;
  logic signed [MW-1:0] sx_min, sx_max, sy_min, sy_max;
  logic dstart, dxdone, dydone;
  logic signed [31:0] qx, qy;
  logic ob_full;

  fcbb_div #(.FRACTION_BITS(FRACTION_BITS)) u_divx (
    .clk, .rst, .start(dstart), .num(cur.x), .den(cur.w), .done(dxdone), .quo(qx));
  fcbb_div #(.FRACTION_BITS(FRACTION_BITS)) u_divy (
    .clk, .rst, .start(dstart), .num(cur.y), .den(cur.w), .done(dydone), .quo(qy));

  assign q_take = state == S_IDLE && !ob_full;
  assign out_valid = ob_full;
  assign idle = state == S_IDLE && !ob_full && !q_valid;

  function automatic logic signed [MW-1:0] scr(logic signed [31:0] v, logic [11:0] h);
    return (ONE + MW'(v)) * $signed({1'b0, h}) + (ONE >>> 1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      box_started <= 1'b0;
      ob_full <= 1'b0;
      dstart <= 1'b0;
    end else begin
      dstart <= 1'b0;
      if (ob_full && !out_stall) ob_full <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_take) begin
            cur <= q_vert;
            if (q_vert.empty) begin
              box_started <= 1'b0;
              visible <= 1'b1;
              ob_full <= 1'b1;
            end else if (q_vert.div) begin
              dstart <= 1'b1;
              state <= S_DIV;
            end else begin
              px <= q_vert.x;
              py <= q_vert.y;
              state <= S_UPD;
            end
          end
        end
        S_DIV: begin
          if (dxdone && dydone) begin
            px <= qx;
            py <= qy;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (!box_started || px < min_x) min_x <= px;
          if (!box_started || px > max_x) max_x <= px;
          if (!box_started || py < min_y) min_y <= py;
          if (!box_started || py > max_y) max_y <= py;
          if (!box_started || cur.z < min_z) min_z <= cur.z;
          if (!box_started || cur.z > max_z) max_z <= cur.z;
          box_started <= !cur.last;
          state <= cur.last ? S_MAP : S_IDLE;
        end
        S_MAP: begin
          sx_min <= scr(min_x, half_width);
          sx_max <= scr(max_x, half_width);
          sy_min <= scr(min_y, half_height);
          sy_max <= scr(max_y, half_height);
          state <= S_TEST;
        end
        S_TEST: begin
          visible <= !(min_z > far_plane || max_z < near_plane ||
                       sy_min > LIMIT || sy_max < 0 || sx_min > LIMIT || sx_max < 0);
          ob_full <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/frustum_cull_bounding_box.sv =====
// Top level of the frustum cull bounding box block: config registers,
// front queue and back engine. Depends on fcbb_pkg, fcbb_front, fcbb_back.
//
//  channel | handshake           | payload
//  vertex  | in_valid / in_stall | vert_x vert_y vert_z vert_w last_vertex empty_mesh
//  result  | out_valid/out_stall | visible
//  config  | cfg_valid/cfg_ready | cfg_index cfg_data
//
// A vertex with positive w goes through the bit-serial divider in the back
// engine, other vertices skip it; a last vertex also passes S_MAP and S_TEST.
// An empty mesh is answered visible from S_IDLE. A two-entry queue lets vertices in
// while the back engine works. rst is synchronous and restores register defaults.
module frustum_cull_bounding_box #(
  parameter int FRACTION_BITS = fcbb_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [31:0]                 vert_x,
  input  logic signed [31:0]                 vert_y,
  input  logic signed [31:0]                 vert_z,
  input  logic signed [31:0]                 vert_w,
  input  logic                               last_vertex,
  input  logic                               empty_mesh,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               visible,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fcbb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);
  logic signed [31:0] near_plane, far_plane;
  logic [11:0] half_width, half_height;
  fcbb_pkg::vert_t in_vert, q_vert;
  logic q_valid, q_take, idle;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_plane <= fcbb_pkg::NEAR_RESET;
      far_plane <= fcbb_pkg::FAR_RESET;
      half_width <= fcbb_pkg::HALF_RESET;
      half_height <= fcbb_pkg::HALF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (fcbb_pkg::reg_idx_t'(cfg_index))
        fcbb_pkg::REG_NEAR_PLANE:  near_plane <= cfg_data;
        fcbb_pkg::REG_FAR_PLANE:   far_plane <= cfg_data;
        fcbb_pkg::REG_HALF_WIDTH:  half_width <= cfg_data[11:0];
        fcbb_pkg::REG_HALF_HEIGHT: half_height <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_vert.x = vert_x;
    in_vert.y = vert_y;
    in_vert.z = vert_z;
    in_vert.w = vert_w;
    in_vert.div = 1'b0;
    in_vert.last = last_vertex;
    in_vert.empty = empty_mesh;
  end

  fcbb_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_vert, .q_valid, .q_take, .q_vert);

  fcbb_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst, .q_valid, .q_take, .q_vert, .near_plane, .far_plane,
    .half_width, .half_height, .out_valid, .out_stall, .visible, .idle);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(visible))
    else $error("result changed while stalled");
  a_idle_no_out: assert property (@(posedge clk) disable iff (rst)
    idle |-> !out_valid)
    else $error("idle with result pending");
  a_queue_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid)
    else $error("stall with empty queue");
endmodule
